// ===== hw/rtl/cps_pkg.sv =====
// Shared constants for the clock phase PI sync block.
// No dependencies; used by the interfaces, the top level, the checkers and the testbench.
package cps_pkg;

	localparam int REF_W   = 63;
	localparam int CYC_W   = 31;
	localparam int PHASE_W = 31;
	localparam int OFF_W   = 64;

	localparam logic [CYC_W-1:0] CYCLE_TIME_RESET = 31'd1000000;

	// Divisors of the correction term
	localparam int OFFSET_DIV   = 700;
	localparam int INTEGRAL_DIV = 20;

	localparam logic signed [OFF_W-1:0] INTEG_MAX = {1'b0, {(OFF_W-1){1'b1}}};
	localparam logic signed [OFF_W-1:0] INTEG_MIN = {1'b1, {(OFF_W-1){1'b0}}};

endpackage

// ===== hw/rtl/cps_if.sv =====
// Valid/ready channel interfaces for the clock phase PI sync block.
// Depends on cps_pkg for the field widths.
interface cps_samp_if import cps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REF_W-1:0] ref_time;

	modport source (output valid, output ref_time, input ready);
	modport sink   (input valid, input ref_time, output ready);
endinterface

interface cps_res_if import cps_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [OFF_W-1:0]   offset_time;
	logic signed [PHASE_W-1:0] phase_error;

	modport source (output valid, output offset_time, output phase_error, input ready);
	modport sink   (input valid, input offset_time, input phase_error, output ready);
endinterface

// ===== hw/rtl/clock_phase_pi_sync.sv =====
// Clock phase PI sync: phase error and correction offset from a reference time.
// Depends on cps_pkg and the channel interfaces in cps_if.sv.
//
// Usage:
//   samp carries one reference time (ns) per transaction; res returns one
//   transaction with offset_time and phase_error for each one accepted.
//   cfg_we/cfg_wdata write the cycle time; write only while the block is idle.
// Timing:
//   The remainder modulo the cycle time is formed by a restoring divider,
//   one dividend bit per cycle. State WRAP then wraps the remainder and
//   steps the integrator, LOAD takes magnitudes, then the two constant
//   divisions (by 700 and by 20) run side by side in DIV, two quotient bits
//   per cycle, the error one in the first half only; NEG negates, and DONE
//   sums into the output register once it is free. One transaction is in
//   work at a time: a new one is taken only after the last one leaves DONE.
// Reset:
//   Cycle time returns to 1000000 ns, the integrator to zero, no result pending.
// Stall:
//   A result waits in the output register until res.ready; the next sample is
//   accepted and worked on meanwhile, and holds in its final step until the
//   output register frees up.
module clock_phase_pi_sync import cps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CYC_W-1:0] cfg_wdata,
	cps_samp_if.sink         samp,
	cps_res_if.source        res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_WRAP = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_NEG  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam int IR_W = $clog2(INTEGRAL_DIV);
	localparam int ER_W = $clog2(OFFSET_DIV);
	localparam int EQ_W = PHASE_W + 1;

	logic [2:0]                state_q;
	logic [5:0]                cnt_q;
	logic [CYC_W-1:0]          cyc_q;
	logic signed [OFF_W-1:0]   integ_q;
	logic [REF_W-1:0]          dvd_q;
	logic [CYC_W-1:0]          rem_q;
	logic signed [PHASE_W-1:0] err_q;
	logic [OFF_W-1:0]          iq_q;
	logic [IR_W-1:0]           ir_q;
	logic                      ineg_q;
	logic [EQ_W-1:0]           eq_q;
	logic [ER_W-1:0]           er_q;
	logic                      eneg_q;
	logic                      res_valid_q;
	logic signed [OFF_W-1:0]   off_q;
	logic signed [PHASE_W-1:0] ph_q;

	// modulo step
	logic [CYC_W:0]   trial;
	logic [CYC_W:0]   trial_sub;
	logic [CYC_W-1:0] rem_n;
	// wrap
	logic signed [PHASE_W-1:0] err_n;
	// radix-4 division steps
	logic [IR_W+1:0] it;
	logic [1:0]      id;
	logic [IR_W+1:0] ir_n;
	logic [ER_W+1:0] et;
	logic [1:0]      ed;
	logic [ER_W+1:0] er_n;
	logic [EQ_W-1:0] err_ext;
	logic            out_free;

	assign trial     = {rem_q, dvd_q[REF_W-1]};
	assign trial_sub = trial - {1'b0, cyc_q};
	assign rem_n     = (trial >= {1'b0, cyc_q}) ? trial_sub[CYC_W-1:0] : trial[CYC_W-1:0];

	always_comb begin
		if (cyc_q == '0) begin
			err_n = '0;
		end else if (rem_q > (cyc_q >> 1)) begin
			err_n = rem_q - cyc_q;
		end else begin
			err_n = rem_q;
		end
	end

	always_comb begin
		it = {ir_q, iq_q[OFF_W-1 -: 2]};
		priority if (it >= (IR_W+2)'(3*INTEGRAL_DIV)) begin
			id   = 2'd3;
			ir_n = it - (IR_W+2)'(3*INTEGRAL_DIV);
		end else if (it >= (IR_W+2)'(2*INTEGRAL_DIV)) begin
			id   = 2'd2;
			ir_n = it - (IR_W+2)'(2*INTEGRAL_DIV);
		end else if (it >= (IR_W+2)'(INTEGRAL_DIV)) begin
			id   = 2'd1;
			ir_n = it - (IR_W+2)'(INTEGRAL_DIV);
		end else begin
			id   = 2'd0;
			ir_n = it;
		end
	end

	always_comb begin
		et = {er_q, eq_q[EQ_W-1 -: 2]};
		priority if (et >= (ER_W+2)'(3*OFFSET_DIV)) begin
			ed   = 2'd3;
			er_n = et - (ER_W+2)'(3*OFFSET_DIV);
		end else if (et >= (ER_W+2)'(2*OFFSET_DIV)) begin
			ed   = 2'd2;
			er_n = et - (ER_W+2)'(2*OFFSET_DIV);
		end else if (et >= (ER_W+2)'(OFFSET_DIV)) begin
			ed   = 2'd1;
			er_n = et - (ER_W+2)'(OFFSET_DIV);
		end else begin
			ed   = 2'd0;
			er_n = et;
		end
	end

	assign err_ext  = {err_q[PHASE_W-1], err_q};
	assign out_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q <= CYCLE_TIME_RESET;
		end else if (cfg_we) begin
			cyc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			integ_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (samp.valid) begin
						state_q <= ST_MOD;
						cnt_q   <= 6'(REF_W - 1);
					end
				end
				ST_MOD: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					// sign integrator, holding at its limits
					if (err_n > 0 && integ_q != INTEG_MAX) begin
						integ_q <= integ_q + 64'sd1;
					end else if (err_n < 0 && integ_q != INTEG_MIN) begin
						integ_q <= integ_q - 64'sd1;
					end
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
					cnt_q   <= 6'(OFF_W/2 - 1);
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= ST_NEG;
					end
				end
				ST_NEG: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				dvd_q <= samp.ref_time;
				rem_q <= '0;
			end
			ST_MOD: begin
				rem_q <= rem_n;
				dvd_q <= {dvd_q[REF_W-2:0], 1'b0};
			end
			ST_WRAP: begin
				err_q <= err_n;
			end
			ST_LOAD: begin
				ineg_q <= integ_q[OFF_W-1];
				iq_q   <= integ_q[OFF_W-1] ? (64'd0 - integ_q) : integ_q;
				ir_q   <= '0;
				eneg_q <= err_q[PHASE_W-1];
				eq_q   <= err_q[PHASE_W-1] ? (EQ_W'(0) - err_ext) : err_ext;
				er_q   <= '0;
			end
			ST_DIV: begin
				iq_q <= {iq_q[OFF_W-3:0], id};
				ir_q <= ir_n[IR_W-1:0];
				// the error magnitude has half the digits; it runs the first half
				if (cnt_q >= 6'(OFF_W/4)) begin
					eq_q <= {eq_q[EQ_W-3:0], ed};
					er_q <= er_n[ER_W-1:0];
				end
			end
			ST_NEG: begin
				// turn each quotient into the negated signed term of the offset
				if (!ineg_q) begin
					iq_q <= 64'd0 - iq_q;
				end
				if (!eneg_q) begin
					eq_q <= EQ_W'(0) - eq_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					off_q <= $signed(iq_q) + {{(OFF_W-EQ_W){eq_q[EQ_W-1]}}, eq_q};
					ph_q  <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign samp.ready      = (state_q == ST_IDLE);
	assign res.valid       = res_valid_q;
	assign res.offset_time = off_q;
	assign res.phase_error = ph_q;

endmodule

// ===== hw/rtl/cps_check.sv =====
// Port-level checker for clock_phase_pi_sync, attached with a bind.
// Depends on cps_pkg for the field widths.
module cps_check import cps_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      samp_valid,
	input logic                      samp_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic signed [OFF_W-1:0]   offset_time,
	input logic signed [PHASE_W-1:0] phase_error
);

	logic samp_acc;
	assign samp_acc = samp_valid && samp_ready;

	// a stalled result holds still
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(offset_time) && $stable(phase_error))
		else $error("result changed while stalled");

	// one transaction in work at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		samp_acc |=> !samp_ready)
		else $error("sample accepted while busy");

	// the serial remainder pass keeps the input closed for its whole length
	a_mod_length: assert property (@(posedge clk) disable iff (!arst_n)
		samp_acc |-> ##63 !samp_ready)
		else $error("input reopened before the remainder pass ended");

	// wrapped error never reaches the most negative code
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> phase_error != {1'b1, {(PHASE_W-1){1'b0}}})
		else $error("phase error outside half-cycle window");

endmodule

bind clock_phase_pi_sync cps_check u_cps_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.samp_valid  (samp.valid),
	.samp_ready  (samp.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.offset_time (res.offset_time),
	.phase_error (res.phase_error)
);

// ===== verif/cps_checker.sv =====
`timescale 1ns / 100ps
// Checker for clock_phase_pi_sync: watches the sample, result and config ports,
// predicts phase error and correction offset per sample and compares results.
// Depends on cps_pkg and the channel interfaces in cps_if.sv.
module cps_checker import cps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CYC_W-1:0] cfg_wdata,
	cps_samp_if              samp,
	cps_res_if               res,
	output int               fail_count,
	output int               outstanding
);

	typedef struct packed {
		logic signed [OFF_W-1:0]   offset_time;
		logic signed [PHASE_W-1:0] phase_error;
	} correction_t;

	logic [CYC_W-1:0]        cycle_time;
	logic signed [OFF_W-1:0] integral;
	correction_t             expected_corrections[$];

	task automatic report_mismatch(input string what);
		// keep the log bounded if the block is badly broken
		if (fail_count < 100) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
		fail_count++;
	endtask

	// One control step: wrap remainder into the half-cycle window, step the
	// sign integrator (saturating), form the correction offset.
	function automatic correction_t predict_correction(input logic [REF_W-1:0] t);
		longint unsigned rem;
		longint          err;
		correction_t     c;
		if (cycle_time == '0) begin
			err = 0;
		end else begin
			rem = {1'b0, t} % {33'd0, cycle_time};
			if (rem > {33'd0, cycle_time >> 1}) begin
				err = $signed(rem) - $signed({33'd0, cycle_time});
			end else begin
				err = $signed(rem);
			end
		end
		if (err > 0 && integral != INTEG_MAX) begin
			integral = integral + 1;
		end
		if (err < 0 && integral != INTEG_MIN) begin
			integral = integral - 1;
		end
		c.offset_time = -(err / OFFSET_DIV) - (integral / INTEGRAL_DIV);
		c.phase_error = err[PHASE_W-1:0];
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		correction_t want;
		if (!arst_n) begin
			cycle_time = CYCLE_TIME_RESET;
			integral   = '0;
			expected_corrections.delete();
			outstanding = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_corrections.size() == 0) begin
					report_mismatch($sformatf("unexpected result: offset %0d phase %0d",
						res.offset_time, res.phase_error));
				end else begin
					want = expected_corrections.pop_front();
					if (res.offset_time !== want.offset_time) begin
						report_mismatch($sformatf("offset_time got %0d want %0d",
							res.offset_time, want.offset_time));
					end
					if (res.phase_error !== want.phase_error) begin
						report_mismatch($sformatf("phase_error got %0d want %0d",
							res.phase_error, want.phase_error));
					end
				end
			end
			if (samp.valid && samp.ready) begin
				expected_corrections.push_back(predict_correction(samp.ref_time));
			end
			// config only changes while idle, after any sample in this cycle
			if (cfg_we) begin
				cycle_time = cfg_wdata;
			end
			outstanding = expected_corrections.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the clock_phase_pi_sync testbench: clock, reset, sample and config
// stimulus, result backpressure and the verdict. Checking is in cps_checker.
// Depends on cps_pkg, cps_if.sv, the RTL top and verif/cps_checker.sv.
module testbench;
	import cps_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LATENCY     = 100;
	localparam int LONG_HOLD   = 400;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 103;

	localparam logic [CYC_W-1:0] CYC_MAX = {CYC_W{1'b1}};
	localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CYC_W-1:0] cfg_wdata;

	cps_samp_if samp ();
	cps_res_if  res ();

	int               fail_count;
	int               outstanding;
	int               cycle_count;
	bit               calm;
	bit               hold_req;
	bit               hold_done;
	logic [CYC_W-1:0] cur_cycle;

	clock_phase_pi_sync u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samp      (samp),
		.res       (res)
	);

	cps_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.samp        (samp),
		.res         (res),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_sample(input logic [REF_W-1:0] t);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			samp.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samp.valid    <= 1'b1;
		samp.ref_time <= t;
		do @(posedge clk); while (!(samp.valid && samp.ready));
		@(negedge clk);
	endtask

	task automatic drain_results();
		samp.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_cycle_time(input logic [CYC_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		cur_cycle = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// bias: 0 any phase, 1 mostly positive error, 2 mostly negative error
	function automatic logic [REF_W-1:0] pick_ref_time(input int bias);
		int unsigned     cyc;
		int unsigned     half;
		int unsigned     sel;
		int unsigned     off;
		longint unsigned t;
		cyc  = {1'b0, cur_cycle};
		half = cyc >> 1;
		sel  = $urandom_range(0, 9);
		if (cyc < 3 && sel > 2) begin
			sel = sel % 3;
		end
		case (sel)
			0, 1: t = {$urandom, $urandom};
			2: t = {32'd0, $urandom_range(0, 4095)};
			default: begin
				if (sel == 3) begin
					off = half - 1 + $urandom_range(0, 2);
				end else if (sel == 4) begin
					// error magnitudes around multiples of the offset divisor
					off = (700 * $urandom_range(0, 3) + $urandom_range(0, 2)) % cyc;
					if ($urandom_range(0, 1) && off != 0) begin
						off = cyc - off;
					end
				end else if (bias == 1) begin
					off = $urandom_range(1, half);
				end else if (bias == 2) begin
					off = $urandom_range(half + 1, cyc - 1);
				end else begin
					off = $urandom_range(0, cyc - 1);
				end
				t = {32'd0, $urandom} * {32'd0, cyc} + {32'd0, off};
			end
		endcase
		return t[REF_W-1:0];
	endfunction

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int gap;
		res.ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				res.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end
			gap = calm ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!(res.valid && res.ready));
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int               bias;
		logic [CYC_W-1:0] phase_cycle;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		samp.valid    = 1'b0;
		samp.ref_time = '0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		cur_cycle     = CYCLE_TIME_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset cycle time, window edges, divisor edges
		send_sample('0);
		send_sample(REF_MAX);
		send_sample(63'd500000);
		send_sample(63'd500001);
		send_sample(63'd1);
		send_sample(63'd999999);
		send_sample(63'd700);
		send_sample(63'd699);
		send_sample(63'd999300);
		send_sample(63'd999301);
		send_sample(63'd3001400);
		// zero cycle time: no error, integrator holds
		write_cycle_time('0);
		send_sample(63'd12345);
		send_sample(REF_MAX);
		write_cycle_time(31'd2);
		send_sample(63'd5);
		send_sample(63'd4);
		write_cycle_time(31'd3);
		send_sample(63'd5);
		send_sample(63'd7);
		// largest cycle: error reaches both ends of its range
		write_cycle_time(CYC_MAX);
		send_sample(63'd1073741823);
		send_sample(63'd1073741824);
		send_sample(REF_MAX);
		send_sample(63'd11811160059);
		send_sample(63'd2147483646);
		write_cycle_time(31'd1);
		send_sample(63'h5555_5555_5555_5555);

		for (int p = 0; p < PHASES; p++) begin
			bias = 0;
			calm = 1'b0;
			case (p)
				0: begin phase_cycle = 31'd1000000; bias = 1; calm = 1'b1; end
				1: begin phase_cycle = 31'd1000000; bias = 1; end
				2: phase_cycle = 31'd3;
				3: begin phase_cycle = CYC_MAX; bias = 2; end
				4: begin
					phase_cycle = CYC_W'($urandom_range(1 << 20, CYC_MAX));
					bias = 2;
				end
				5: begin phase_cycle = 31'd700; bias = 2; calm = 1'b1; end
				6: phase_cycle = CYC_W'($urandom_range(2, 4096));
				7: phase_cycle = 31'd1;
				8: phase_cycle = 31'd1000000;
				default: begin
					phase_cycle = CYC_W'($urandom_range(1, CYC_MAX));
					bias = 1;
				end
			endcase
			write_cycle_time(phase_cycle);
			// result side stops for a long while; input must back up
			if (p == 1) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 8 && n == PHASE_ITEMS / 2) begin
					drain_results();
				end
				send_sample(pick_ref_time(bias));
			end
		end

		drain_results();
		repeat (LATENCY + 20) @(negedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
